### rtl/pcsp_pkg.sv
// shared types, character codes and helpers for the conversion spec parser
// no dependencies
`timescale 1ns / 1ps

package pcsp_pkg;

   // bits of the saturation limit, capped by the 31-bit field width
   localparam int NUM_BITS = 31;
   localparam int FW_W     = 31;
   localparam int PREC_W   = 32;

   localparam logic [FW_W-1:0] LIMIT = (NUM_BITS >= FW_W) ? {FW_W{1'b1}} :
                                       FW_W'((64'd1 << NUM_BITS) - 64'd1);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_BLANK = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_LOW_H = 8'h68;
   localparam logic [7:0] CH_LOW_L = 8'h6C;
   localparam logic [7:0] CH_LOW_J = 8'h6A;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CH_UP_L  = 8'h4C;
   localparam logic [7:0] CH_LOW_T = 8'h74;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_STAR  = 8'h2A;

   // flag and modifier bit positions
   localparam int FL_PLUS  = 0;
   localparam int FL_MINUS = 1;
   localparam int FL_HASH  = 2;
   localparam int FL_ZERO  = 3;
   localparam int FL_BLANK = 4;
   localparam int FL_QUOTE = 5;

   localparam int MD_HH = 0;
   localparam int MD_H  = 1;
   localparam int MD_LL = 2;
   localparam int MD_L  = 3;
   localparam int MD_J  = 4;
   localparam int MD_Z  = 5;
   localparam int MD_LD = 6;
   localparam int MD_T  = 7;

   typedef struct packed {
      logic        [7:0]  ch;
      logic signed [31:0] star_value;
   } req_type;

   typedef struct packed {
      logic        [5:0]        flag_bits;
      logic        [7:0]        modifier_bits;
      logic        [FW_W-1:0]   field_width;
      logic signed [PREC_W-1:0] precision_value;
      logic        [7:0]        conversion;
   } rsp_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // acc * 10 + d, saturated at the limit
   function automatic logic [FW_W-1:0] acc_digit(input logic [FW_W-1:0] acc,
                                                 input logic [3:0] d);
      logic [FW_W+3:0] sum;
      sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{FW_W{1'b0}}, d};
      if (sum > {4'b0000, LIMIT})
         return LIMIT;
      return sum[FW_W-1:0];
   endfunction

endpackage

### rtl/pcsp_core.sv
// parser state and per-character next-state and result logic
// depends on pcsp_pkg
`timescale 1ns / 1ps

module pcsp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  pcsp_pkg::req_type req,
   output logic              has_result,
   output pcsp_pkg::rsp_type result
);
   import pcsp_pkg::*;

   typedef enum logic [2:0] {
      PH_NORMAL = 3'd0,
      PH_WIDTH  = 3'd1,
      PH_DOT    = 3'd2,
      PH_PREC   = 3'd3,
      PH_HPEND  = 3'd4,
      PH_LPEND  = 3'd5
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic        [5:0]        flags_ff, flags_in;
   logic        [7:0]        mods_ff, mods_in;
   logic        [FW_W-1:0]   width_ff, width_in;
   logic signed [PREC_W-1:0] prec_ff, prec_in;

   logic              do_normal;
   logic              ch_digit;
   logic [3:0]        dval;
   logic [31:0]       star_mag;
   logic [FW_W-1:0]   star_width;
   logic [FW_W-1:0]   star_prec;

   assign ch_digit = is_digit(req.ch);
   assign dval     = req.ch[3:0];
   assign star_mag = req.star_value[31] ? 32'(-req.star_value) : 32'(req.star_value);
   assign star_width = (star_mag > {1'b0, LIMIT}) ? LIMIT : star_mag[FW_W-1:0];
   assign star_prec  = (req.star_value[30:0] > LIMIT) ? LIMIT : req.star_value[30:0];

   always_comb begin
      phase_in   = PH_NORMAL;
      flags_in   = flags_ff;
      mods_in    = mods_ff;
      width_in   = width_ff;
      prec_in    = prec_ff;
      do_normal  = 1'b1;
      has_result = 1'b0;
      result     = '0;

      unique case (phase_ff)
         PH_WIDTH: begin
            if (ch_digit) begin
               width_in  = acc_digit(width_ff, dval);
               phase_in  = PH_WIDTH;
               do_normal = 1'b0;
            end
         end
         PH_DOT: begin
            if (req.ch == CH_STAR) begin
               prec_in   = req.star_value[31] ? -32'sd1 : $signed({1'b0, star_prec});
               do_normal = 1'b0;
            end else if (ch_digit) begin
               prec_in   = $signed({1'b0, acc_digit('0, dval)});
               phase_in  = PH_PREC;
               do_normal = 1'b0;
            end else begin
               prec_in = '0;
            end
         end
         PH_PREC: begin
            if (ch_digit) begin
               prec_in   = $signed({1'b0, acc_digit(prec_ff[FW_W-1:0], dval)});
               phase_in  = PH_PREC;
               do_normal = 1'b0;
            end
         end
         PH_HPEND: begin
            if (req.ch == CH_LOW_H) begin
               mods_in[MD_HH] = 1'b1;
               do_normal      = 1'b0;
            end else begin
               mods_in[MD_H] = 1'b1;
            end
         end
         PH_LPEND: begin
            if (req.ch == CH_LOW_L) begin
               mods_in[MD_LL] = 1'b1;
               do_normal      = 1'b0;
            end else begin
               mods_in[MD_L] = 1'b1;
            end
         end
         default: ;
      endcase

      if (do_normal) begin
         unique case (req.ch)
            CH_PLUS:  flags_in[FL_PLUS]  = 1'b1;
            CH_MINUS: flags_in[FL_MINUS] = 1'b1;
            CH_HASH:  flags_in[FL_HASH]  = 1'b1;
            CH_ZERO:  flags_in[FL_ZERO]  = 1'b1;
            CH_BLANK: flags_in[FL_BLANK] = 1'b1;
            CH_QUOTE: flags_in[FL_QUOTE] = 1'b1;
            CH_LOW_H: phase_in = PH_HPEND;
            CH_LOW_L: phase_in = PH_LPEND;
            CH_LOW_J: mods_in[MD_J]  = 1'b1;
            CH_LOW_Z: mods_in[MD_Z]  = 1'b1;
            CH_UP_L:  mods_in[MD_LD] = 1'b1;
            CH_LOW_T: mods_in[MD_T]  = 1'b1;
            CH_DOT:   phase_in = PH_DOT;
            CH_STAR: begin
               if (req.star_value[31])
                  flags_in[FL_MINUS] = 1'b1;
               width_in = star_width;
            end
            default: begin
               if (ch_digit) begin
                  width_in = acc_digit('0, dval);
                  phase_in = PH_WIDTH;
               end else begin
                  // terminating character or end of string
                  has_result             = 1'b1;
                  result.flag_bits       = flags_in;
                  result.modifier_bits   = mods_in;
                  result.field_width     = width_in;
                  result.precision_value = prec_in;
                  result.conversion      = req.ch;
                  phase_in = PH_NORMAL;
                  flags_in = '0;
                  mods_in  = '0;
                  width_in = '0;
                  prec_in  = -32'sd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         flags_ff <= '0;
         mods_ff  <= '0;
         width_ff <= '0;
         prec_ff  <= -32'sd1;
      end else if (advance) begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         mods_ff  <= mods_in;
         width_ff <= width_in;
         prec_ff  <= prec_in;
      end
   end

endmodule

### rtl/printf_conversion_spec_parser.sv
// printf conversion spec parser: request register, parser core, response register
// a terminating request is held in the request register; its result is then registered
// in the response register, from which rsp is driven
// throughput: one character per cycle unless the response stalls; the parser next state is combinational
// a stalled response holds the core and the request register, then request intake
// reset (synchronous, active high) empties both registers and clears the parser state
`timescale 1ns / 1ps

module printf_conversion_spec_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcsp_pkg::rsp_type rsp_data
);
   import pcsp_pkg::*;

   req_type req_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;

   logic    out_free;
   logic    advance;
   logic    req_take;
   logic    has_result;
   rsp_type result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   pcsp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req        (req_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_comb begin
      if (req_take)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;

      if (advance)
         rsp_valid_in = has_result;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take)
         req_ff <= req_data;
      if (advance && has_result)
         rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a blocked request must still be there next cycle
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("held request lost");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.precision_value >= -32'sd1)
      else $error("precision below -1");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.field_width <= LIMIT)
      else $error("width above saturation limit");

   // the dot, star, plus and lowercase l spec characters never terminate a spec
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.conversion != CH_DOT && rsp_data.conversion != CH_STAR &&
                    rsp_data.conversion != CH_PLUS && rsp_data.conversion != CH_LOW_L)
      else $error("spec character emitted as conversion");

endmodule
